// ===== sv/dwbs_pkg.sv =====
package dwbs_pkg;

	localparam int DEPTH    = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;

	localparam logic [ADDR_W:0]  DEPTH_A = (ADDR_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CONTAINS   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// ring slot of a logical position counted from the head
	function automatic logic [ADDR_W-1:0] dwbs_slot(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W-1:0] pos);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, pos};
		if (sum >= DEPTH_A) begin
			sum = sum - DEPTH_A;
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ===== sv/dwbs_ram.sv =====
module dwbs_ram #(
	parameter int DATA_W    = 32,
	parameter int NUM_WORDS = 16
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_WORDS)-1:0] wr_addr,
	input  logic [DATA_W-1:0]            wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(NUM_WORDS)-1:0] rd_addr,
	output logic [DATA_W-1:0]            rd_data
);

	logic [DATA_W-1:0] mem_q [NUM_WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/deque_with_bag_search_core.sv =====
// Bounded double-ended queue of signed 32-bit values held in a ring buffer of DEPTH
// entries (one single-port-read RAM). Each request beat gives exactly one response beat
// carrying status, found flag, front and back values (zero when empty) and the count.
// One request is worked at a time: the block raises req_stall from the beat after a
// request is taken until the response has been loaded into the output register, and it
// takes the next request while that response still waits on rsp_stall. Pushes, pops and
// unused codes go from the execute step to the front and back read-back, whose reads are
// skipped on an empty queue; contains on a non-empty queue first walks the ring, and remove
// also closes the gap behind its first match. The walk is set by the RAM's single read port,
// which reads the stored entries one per cycle for the search and for closing the gap, and
// then reads the front and the back for the response.
module deque_with_bag_search_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [dwbs_pkg::REQ_W-1:0]           req_type,
	input  logic signed [dwbs_pkg::DATA_W-1:0]   item_value,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [dwbs_pkg::STATUS_W-1:0]        status,
	output logic                                 found,
	output logic signed [dwbs_pkg::DATA_W-1:0]  front_value,
	output logic signed [dwbs_pkg::DATA_W-1:0]  back_value,
	output logic [dwbs_pkg::CNT_W-1:0]           item_count
);

	import dwbs_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RDF   = 3'd4;
	localparam logic [2:0] S_RDB   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   head_q;
	logic [CNT_W-1:0]    cnt_q;

	// working registers of the request in flight
	logic [REQ_W-1:0]    req_q;
	logic [DATA_W-1:0]   val_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [DATA_W-1:0]   front_q;

	// walk pointers of the search and the gap closing
	logic [CNT_W-1:0]    rd_pos_q;
	logic [CNT_W-1:0]    cmp_pos_q;
	logic [CNT_W-1:0]    wr_pos_q;
	logic                cmp_valid_q;
	logic                pend_q;

	// output register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [DATA_W-1:0]   front_value_q;
	logic [DATA_W-1:0]   back_value_q;
	logic [CNT_W-1:0]    item_count_q;

	// RAM port
	logic                ram_wr_en;
	logic [ADDR_W-1:0]   ram_wr_addr;
	logic [DATA_W-1:0]   ram_wr_data;
	logic                ram_rd_en;
	logic [ADDR_W-1:0]   ram_rd_addr;
	logic [DATA_W-1:0]   ram_rd_data;

	logic                accept;
	logic                load_rsp;
	logic                full;
	logic                empty;
	logic [CNT_W-1:0]    cnt_m1;
	logic [ADDR_W-1:0]   head_dec;
	logic [ADDR_W-1:0]   head_inc;
	logic                rd_issue;
	logic                match;
	logic                scan_last;

	assign accept    = (state_q == S_IDLE) && req_valid;
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign full      = (cnt_q >= DEPTH_C);
	assign empty     = (cnt_q == '0);
	assign cnt_m1    = cnt_q - 1'b1;
	assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc  = dwbs_slot(head_q, ADDR_W'(1));
	assign rd_issue  = (rd_pos_q < cnt_q);
	// the one value comparator: stored entry against the request value
	assign match     = cmp_valid_q && (ram_rd_data == val_q);
	assign scan_last = cmp_valid_q && (cmp_pos_q == cnt_m1);

	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign item_count  = item_count_q;

	// steer the RAM ports from the sequencer state
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = val_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		case (state_q)
			S_EXEC: begin
				if (req_q == REQ_PUSH_FRONT && !full) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = head_dec;
				end else if (req_q == REQ_PUSH_BACK && !full) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = dwbs_slot(head_q, cnt_q[ADDR_W-1:0]);
				end
			end
			S_SCAN: begin
				ram_rd_en   = rd_issue;
				ram_rd_addr = dwbs_slot(head_q, rd_pos_q[ADDR_W-1:0]);
			end
			S_SHIFT: begin
				// read one place ahead, write the word back one place nearer the front
				ram_rd_en   = rd_issue;
				ram_rd_addr = dwbs_slot(head_q, rd_pos_q[ADDR_W-1:0]);
				ram_wr_en   = pend_q;
				ram_wr_addr = dwbs_slot(head_q, wr_pos_q[ADDR_W-1:0]);
				ram_wr_data = ram_rd_data;
			end
			S_RDF: begin
				ram_rd_en   = !empty;
				ram_rd_addr = head_q;
			end
			S_RDB: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = dwbs_slot(head_q, cnt_m1[ADDR_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	dwbs_ram #(
		.DATA_W    (DATA_W),
		.NUM_WORDS (DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			cnt_q        <= '0;
			res_status_q <= ST_OK;
			res_found_q  <= 1'b0;
			rd_pos_q     <= '0;
			cmp_pos_q    <= '0;
			wr_pos_q     <= '0;
			cmp_valid_q  <= 1'b0;
			pend_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// a fresh load wins over dropping the beat just taken
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_found_q  <= 1'b0;
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					// searches on a non-empty queue walk the ring, everything else goes to the read-back
					if ((req_q == REQ_CONTAINS || req_q == REQ_REMOVE) && !empty) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_RDF;
					end
					case (req_q)
						REQ_PUSH_FRONT: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								head_q <= head_dec;
								cnt_q  <= cnt_q + 1'b1;
							end
						end
						REQ_PUSH_BACK: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								head_q <= head_inc;
								cnt_q  <= cnt_m1;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								cnt_q <= cnt_m1;
							end
						end
						REQ_CONTAINS, REQ_REMOVE: begin
							if (empty) begin
								res_status_q <= ST_EMPTY;
							end else begin
								rd_pos_q    <= '0;
								cmp_valid_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				S_SCAN: begin
					if (match) begin
						res_found_q <= 1'b1;
						if (req_q == REQ_REMOVE) begin
							// close the gap from the first match onwards
							wr_pos_q <= cmp_pos_q;
							rd_pos_q <= cmp_pos_q + 1'b1;
							pend_q   <= 1'b0;
							state_q  <= S_SHIFT;
						end else begin
							state_q <= S_RDF;
						end
					end else if (scan_last) begin
						state_q <= S_RDF;
					end else begin
						if (rd_issue) begin
							rd_pos_q <= rd_pos_q + 1'b1;
						end
						cmp_valid_q <= rd_issue;
						cmp_pos_q   <= rd_pos_q;
					end
				end
				S_SHIFT: begin
					if (pend_q) begin
						wr_pos_q <= wr_pos_q + 1'b1;
					end
					if (rd_issue) begin
						rd_pos_q <= rd_pos_q + 1'b1;
					end
					pend_q <= rd_issue;
					if (!rd_issue && !pend_q) begin
						cnt_q   <= cnt_m1;
						state_q <= S_RDF;
					end
				end
				S_RDF: begin
					state_q <= empty ? S_DONE : S_RDB;
				end
				S_RDB: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here while an earlier response still waits
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			val_q <= item_value;
		end
		if (state_q == S_RDB) begin
			front_q <= ram_rd_data;
		end
		if (load_rsp) begin
			status_q      <= res_status_q;
			found_q       <= res_found_q;
			front_value_q <= empty ? '0 : front_q;
			back_value_q  <= empty ? '0 : ram_rd_data;
			item_count_q  <= cnt_q;
		end
	end

	// a taken request keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while the previous one was still open");

	// a full report only ever comes with a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> item_count == DEPTH_C)
		else $error("full status with a queue that is not full");

	// an empty report leaves nothing stored and zero values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> item_count == '0 && front_value == '0
			&& back_value == '0 && !found)
		else $error("empty status with stored values or a match");

	// the stored count never passes the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> cnt_q <= DEPTH_C)
		else $error("stored count beyond ring depth");

endmodule

// ===== dv/tb_deque_with_bag_search_core.sv =====
`timescale 1ns / 1ps

module tb_deque_with_bag_search_core;
	import dwbs_pkg::*;

	// Request codes the block treats as no-ops; the package names only the six live ones.
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	localparam int IDLE_MAX     = 17;
	localparam int HOLD_OFF     = 160;
	localparam int SETTLE_LIMIT = 5000;
	// The whole run is roughly 600 beats; the watchdog allows it ample time.
	localparam int TIMEOUT_NS   = 1_000_000;

	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic                       found;
		logic signed [DATA_W-1:0]   front_value;
		logic signed [DATA_W-1:0]   back_value;
		logic [CNT_W-1:0]           item_count;
	} deque_rsp_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	logic [REQ_W-1:0]           req_type = '0;
	logic signed [DATA_W-1:0]   item_value = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic                       found;
	logic signed [DATA_W-1:0]   front_value;
	logic signed [DATA_W-1:0]   back_value;
	logic [CNT_W-1:0]           item_count;

	// Shadow copy of the deque contents, updated as each request beat is taken.
	logic signed [DATA_W-1:0]   shadow_ring [DEPTH];
	logic [ADDR_W-1:0]          shadow_head = '0;
	logic [CNT_W-1:0]           shadow_count = '0;

	// Responses owed by the block, oldest first.
	deque_rsp_t                 owed_rsp [$];

	// Idle shaping: upper bound of per-beat waits on each side, plus the long hold-off.
	int unsigned                send_gap_max = IDLE_MAX;
	int unsigned                rsp_gap_max = IDLE_MAX;
	int unsigned                rsp_wait = 0;
	int unsigned                hold_left = 0;

	int unsigned                mismatch_count = 0;
	int unsigned                rsp_checked = 0;
	int unsigned                req_seen [8];
	int unsigned                full_rejects = 0;
	int unsigned                empty_rejects = 0;
	int unsigned                search_hits = 0;
	int unsigned                peak_count = 0;

	deque_with_bag_search_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.item_value  (item_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found       (found),
		.front_value (front_value),
		.back_value  (back_value),
		.item_count  (item_count)
	);

	always #1 clk = ~clk;

	// Ring index of the logical position pos counted from the shadow head.
	function automatic logic [ADDR_W-1:0] ring_slot(input int pos);
		return ADDR_W'((int'(shadow_head) + pos) % DEPTH);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Apply one request to the shadow deque and queue the response it must produce.
	task automatic apply_to_shadow_deque(input logic [REQ_W-1:0] op,
		input logic signed [DATA_W-1:0] val);
		deque_rsp_t exp_rsp;
		int hit;
		int pos;
		exp_rsp = '0;
		hit = -1;
		case (op)
			REQ_PUSH_FRONT: begin
				if (shadow_count >= DEPTH_C) begin
					exp_rsp.status = ST_FULL;
				end else begin
					shadow_head = ADDR_W'((int'(shadow_head) + DEPTH - 1) % DEPTH);
					shadow_ring[shadow_head] = val;
					shadow_count++;
				end
			end
			REQ_PUSH_BACK: begin
				if (shadow_count >= DEPTH_C) begin
					exp_rsp.status = ST_FULL;
				end else begin
					shadow_ring[ring_slot(int'(shadow_count))] = val;
					shadow_count++;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_count == 0) begin
					exp_rsp.status = ST_EMPTY;
				end else begin
					shadow_head = ring_slot(1);
					shadow_count--;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_count == 0) begin
					exp_rsp.status = ST_EMPTY;
				end else begin
					shadow_count--;
				end
			end
			REQ_CONTAINS, REQ_REMOVE: begin
				if (shadow_count == 0) begin
					exp_rsp.status = ST_EMPTY;
				end else begin
					// first match counted from the front
					for (pos = 0; pos < int'(shadow_count); pos++) begin
						if (shadow_ring[ring_slot(pos)] == val) begin
							hit = pos;
							break;
						end
					end
					exp_rsp.found = (hit >= 0);
					if (hit >= 0 && op == REQ_REMOVE) begin
						// close the gap towards the front
						for (pos = hit; pos + 1 < int'(shadow_count); pos++) begin
							shadow_ring[ring_slot(pos)] = shadow_ring[ring_slot(pos + 1)];
						end
						shadow_count--;
					end
				end
			end
			default: begin
			end
		endcase

		if (shadow_count != 0) begin
			exp_rsp.front_value = shadow_ring[shadow_head];
			exp_rsp.back_value  = shadow_ring[ring_slot(int'(shadow_count) - 1)];
		end
		exp_rsp.item_count = shadow_count;

		if (exp_rsp.status == ST_FULL) full_rejects++;
		if (exp_rsp.status == ST_EMPTY) empty_rejects++;
		if (exp_rsp.found) search_hits++;
		if (shadow_count > peak_count) peak_count = 32'(shadow_count);
		owed_rsp.push_back(exp_rsp);
	endtask

	// Offer one request beat after a random idle gap and hold it until taken. Valid is
	// left high on return, so a following zero-gap beat goes out without a bubble.
	task automatic send_request(input logic [REQ_W-1:0] op,
		input logic signed [DATA_W-1:0] val);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type   <= op;
		item_value <= val;
		req_valid  <= 1'b1;
		forever begin
			@(posedge clk);
			if (!req_stall) break;
		end
		req_seen[op]++;
		apply_to_shadow_deque(op, val);
	endtask

	// Value source: half the time something already stored, so searches and removals hit,
	// with extremes, a small alphabet for duplicates, and full-range noise.
	function automatic logic signed [DATA_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50 && shadow_count != 0) begin
			return shadow_ring[ring_slot($urandom_range(0, int'(shadow_count) - 1))];
		end
		if (roll < 62) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		if (roll < 80) return DATA_W'($urandom_range(0, 7));
		return $urandom();
	endfunction

	function automatic logic [REQ_W-1:0] pick_any_op();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 22) return REQ_PUSH_FRONT;
		if (roll < 44) return REQ_PUSH_BACK;
		if (roll < 56) return REQ_POP_FRONT;
		if (roll < 68) return REQ_POP_BACK;
		if (roll < 82) return REQ_CONTAINS;
		if (roll < 96) return REQ_REMOVE;
		return ($urandom_range(0, 1) != 0) ? REQ_SPARE_7 : REQ_SPARE_6;
	endfunction

	// Response side: hold stall for the long hold-off first, then for the wait drawn
	// after the last response beat, else take whatever comes.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (rsp_wait != 0) begin
			rsp_stall <= 1'b1;
			rsp_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare every response beat against the oldest owed response, field by field.
	always @(posedge clk) begin : rsp_check
		deque_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_wait = $urandom_range(0, rsp_gap_max);
			if (owed_rsp.size() == 0) begin
				report_mismatch($sformatf("response beat %0d with nothing owed", rsp_checked));
			end else begin
				want = owed_rsp.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("beat %0d status %0d, want %0d",
						rsp_checked, status, want.status));
				if (found !== want.found)
					report_mismatch($sformatf("beat %0d found %0b, want %0b",
						rsp_checked, found, want.found));
				if (front_value !== want.front_value)
					report_mismatch($sformatf("beat %0d front %0d, want %0d",
						rsp_checked, front_value, want.front_value));
				if (back_value !== want.back_value)
					report_mismatch($sformatf("beat %0d back %0d, want %0d",
						rsp_checked, back_value, want.back_value));
				if (item_count !== want.item_count)
					report_mismatch($sformatf("beat %0d count %0d, want %0d",
						rsp_checked, item_count, want.item_count));
			end
			rsp_checked++;
		end
	end

	// Empty-queue errors, spare codes, both ends at the value extremes, a search that
	// hits the last element, first-match-only removal and a removal that misses.
	task automatic test_directed_edges();
		send_request(REQ_POP_FRONT, 32'sd5);
		send_request(REQ_POP_BACK, VAL_MIN);
		send_request(REQ_CONTAINS, '0);
		send_request(REQ_REMOVE, '0);
		send_request(REQ_SPARE_6, VAL_MAX);
		send_request(REQ_SPARE_7, -1);
		send_request(REQ_PUSH_BACK, VAL_MAX);
		send_request(REQ_PUSH_FRONT, VAL_MIN);
		send_request(REQ_PUSH_BACK, '0);
		send_request(REQ_PUSH_BACK, -1);
		send_request(REQ_PUSH_FRONT, VAL_MAX);
		send_request(REQ_CONTAINS, -1);
		send_request(REQ_CONTAINS, VAL_MIN);
		send_request(REQ_CONTAINS, 32'sd12345);
		// two copies of the maximum: each removal takes only the one nearest the front
		send_request(REQ_REMOVE, VAL_MAX);
		send_request(REQ_REMOVE, VAL_MAX);
		send_request(REQ_REMOVE, 32'sd777);
		send_request(REQ_REMOVE, -1);
		send_request(REQ_SPARE_7, '0);
		send_request(REQ_POP_FRONT, -1);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_POP_BACK, '0);
	endtask

	// Free mix of every request type with stored-value-biased operands.
	task automatic test_random_mix(input int unsigned beats);
		repeat (beats) send_request(pick_any_op(), pick_value());
	endtask

	// Swing between full and empty: mostly pushes until full, linger there so pushes
	// bounce, then mostly pops and removals down to empty and linger again.
	task automatic test_fill_and_drain(input int unsigned beats);
		logic filling;
		logic [REQ_W-1:0] op;
		filling = 1'b1;
		repeat (beats) begin
			if ($urandom_range(0, 99) < 80) begin
				if (filling)
					op = ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				else
					case ($urandom_range(0, 2))
						0: op = REQ_POP_FRONT;
						1: op = REQ_POP_BACK;
						default: op = REQ_REMOVE;
					endcase
			end else begin
				op = pick_any_op();
			end
			send_request(op, pick_value());
			if (filling && shadow_count == DEPTH_C && $urandom_range(0, 2) == 0)
				filling = 1'b0;
			else if (!filling && shadow_count == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
		end
	endtask

	// No idling on either side: beats go back to back.
	task automatic test_back_to_back(input int unsigned beats);
		send_gap_max = 0;
		rsp_gap_max  = 0;
		repeat (beats) send_request(pick_any_op(), pick_value());
		send_gap_max = IDLE_MAX;
		rsp_gap_max  = IDLE_MAX;
	endtask

	// Hold the response side off for a long stretch while requests keep coming, so the
	// block backs up and stalls its request side.
	task automatic test_receiver_hold_off(input int unsigned beats);
		send_gap_max = 0;
		hold_left = HOLD_OFF;
		repeat (beats) send_request(pick_any_op(), pick_value());
		send_gap_max = IDLE_MAX;
	endtask

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("deque_with_bag_search_core verification failed");
		$finish;
	end

	initial begin : run
		int unsigned settle;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_random_mix(300);
		test_fill_and_drain(160);
		test_back_to_back(100);
		test_receiver_hold_off(30);

		@(negedge clk);
		req_valid <= 1'b0;

		// let the owed responses drain, then give the block time to show a stray beat
		for (settle = 0; settle < SETTLE_LIMIT && owed_rsp.size() != 0; settle++)
			@(posedge clk);
		if (owed_rsp.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", owed_rsp.size()));
		repeat (DEPTH + 24) @(posedge clk);

		$display("summary: pushes %0d/%0d, pops %0d/%0d, contains %0d, removes %0d, spare %0d",
			req_seen[REQ_PUSH_FRONT], req_seen[REQ_PUSH_BACK], req_seen[REQ_POP_FRONT],
			req_seen[REQ_POP_BACK], req_seen[REQ_CONTAINS], req_seen[REQ_REMOVE],
			req_seen[REQ_SPARE_6] + req_seen[REQ_SPARE_7]);
		$display("summary: %0d responses checked, %0d full, %0d empty, %0d hits, peak %0d",
			rsp_checked, full_rejects, empty_rejects, search_hits, peak_count);

		if (mismatch_count == 0) begin
			$display("deque_with_bag_search_core verification clean");
		end else begin
			$display("deque_with_bag_search_core verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/dwbs_pkg.sv
sv/dwbs_ram.sv
sv/deque_with_bag_search_core.sv
dv/tb_deque_with_bag_search_core.sv
